FILE: hdl/cmw_pkg.sv
// Shared types, constants and fixed-point helpers for the cloud-in-cell
// corner weight pipeline. No dependencies; used by every file in hdl/.
package cmw_pkg;

    // Fixed-point layout
    localparam int FRACTION_BITS = 22;
    localparam int POS_W         = 32;
    localparam int MASS_W        = 32;
    localparam int TAG_W         = 24;
    localparam int GRID_W        = 10;
    localparam int CFG_W         = 32;
    localparam int IDX_W         = 2;
    localparam int CORNER_W      = 3;
    localparam int AXES          = 3;
    localparam int PROD_W        = 64;
    localparam int WGT_W         = 33;   // Q1.32, 0 .. 1.0 inclusive

    // pos * inv_cell carries FRACTION_BITS + 16 fraction bits
    localparam int FB = FRACTION_BITS + 16;
    localparam logic [PROD_W-1:0] FRAC_MASK = PROD_W'((65'd1 << FB) - 65'd1);
    localparam logic [PROD_W-1:0] FRAC_HALF = PROD_W'(65'd1 << (FB - 1));
    localparam logic [WGT_W-1:0]  ONE_Q32   = {1'b1, 32'b0};

    // Width for comparing a 33-bit sum against the box size
    localparam int EXT_W = GRID_W + FRACTION_BITS;
    localparam int CMP_W = (EXT_W > POS_W + 1) ? EXT_W : POS_W + 1;

    localparam logic [CORNER_W-1:0] LAST_CORNER = '1;

    // Reset values of the configuration registers
    localparam logic [POS_W-1:0]  HALF_CELL_RST   = 32'd2097152;
    localparam logic [CFG_W-1:0]  INV_CELL_RST    = 32'd65536;
    localparam logic [GRID_W-1:0] GRID_EXTENT_RST = 10'd256;

    typedef enum logic [IDX_W-1:0] {
        REG_HALF_CELL   = 2'd0,
        REG_INV_CELL    = 2'd1,
        REG_GRID_EXTENT = 2'd2
    } reg_index_t;

    // Per-axis data of one particle
    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [WGT_W-1:0] wl;
        logic [WGT_W-1:0] wh;
    } axis_t;

    typedef struct packed {
        axis_t [AXES-1:0]  ax;
        logic [MASS_W-1:0] mass;
        logic [TAG_W-1:0]  tag;
    } particle_t;

    // Fraction of pos*inv + 0.5, as an upper-side weight in Q1.32.
    // Adding one half modulo 2^FB only flips the top fraction bit.
    function automatic logic [WGT_W-1:0] upper_weight(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0]    frac;
        logic [PROD_W+31:0]   scaled;
        frac   = (prod & FRAC_MASK) ^ FRAC_HALF;
        scaled = {frac, 32'b0} >> FB;
        return {1'b0, scaled[31:0]};
    endfunction

    // a (Q0.32) times w (Q1.32), truncated; a weight of one passes a through
    function automatic logic [MASS_W-1:0] mul_weight(input logic [MASS_W-1:0] a,
                                                     input logic [WGT_W-1:0] w);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(w[31:0]);
        return w[32] ? a : p[PROD_W-1:32];
    endfunction

endpackage

FILE: hdl/cmw_front.sv
// Particle front end: input registers, position products and corner wrap,
// then per-axis weights. Depends on cmw_pkg.
module cmw_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cmw_pkg::POS_W-1:0]    pos_x,
    input  logic [cmw_pkg::POS_W-1:0]    pos_y,
    input  logic [cmw_pkg::POS_W-1:0]    pos_z,
    input  logic [cmw_pkg::MASS_W-1:0]   mass_in,
    input  logic [cmw_pkg::TAG_W-1:0]    particle_tag,
    input  logic [cmw_pkg::POS_W-1:0]    half_cell,
    input  logic [cmw_pkg::CFG_W-1:0]    inv_cell,
    input  logic [cmw_pkg::GRID_W-1:0]   grid_extent,
    output logic                         part_valid,
    output cmw_pkg::particle_t           part,
    input  logic                         part_take
);

    // Stage 0: captured item
    logic                       v0_reg;
    logic [cmw_pkg::POS_W-1:0]  pos_reg [cmw_pkg::AXES];
    logic [cmw_pkg::MASS_W-1:0] mass0_reg;
    logic [cmw_pkg::TAG_W-1:0]  tag0_reg;

    // Stage 1: products and wrapped corners
    logic                        v1_reg;
    logic [cmw_pkg::PROD_W-1:0]  prod_reg [cmw_pkg::AXES];
    logic [cmw_pkg::PROD_W-1:0]  prod_next [cmw_pkg::AXES];
    logic [cmw_pkg::POS_W-1:0]   lo_reg [cmw_pkg::AXES];
    logic [cmw_pkg::POS_W-1:0]   lo_next [cmw_pkg::AXES];
    logic [cmw_pkg::POS_W-1:0]   hi_reg [cmw_pkg::AXES];
    logic [cmw_pkg::POS_W-1:0]   hi_next [cmw_pkg::AXES];
    logic [cmw_pkg::MASS_W-1:0]  mass1_reg;
    logic [cmw_pkg::TAG_W-1:0]   tag1_reg;

    // Stage 2: finished particle
    logic               v2_reg;
    cmw_pkg::particle_t part_reg;
    cmw_pkg::particle_t part_next;

    logic move0, move1, move2, accept;
    logic [cmw_pkg::CMP_W-1:0] ext;

    // Stall chain: a stage moves when empty or when the next one moves
    assign move2  = !v2_reg || part_take;
    assign move1  = !v1_reg || move2;
    assign move0  = !v0_reg || move1;
    assign busy   = !move0;
    assign accept = start && move0;

    assign ext = cmw_pkg::CMP_W'({grid_extent, {cmw_pkg::FRACTION_BITS{1'b0}}});

    // Products and one-shot periodic wrap per axis
    always_comb
    begin
        logic [cmw_pkg::POS_W:0] diff;
        logic [cmw_pkg::POS_W:0] sum;
        for (int a = 0; a < cmw_pkg::AXES; a++)
        begin
            prod_next[a] = cmw_pkg::PROD_W'(pos_reg[a]) * cmw_pkg::PROD_W'(inv_cell);
            diff = {1'b0, pos_reg[a]} - {1'b0, half_cell};
            sum  = {1'b0, pos_reg[a]} + {1'b0, half_cell};
            lo_next[a] = diff[cmw_pkg::POS_W] ? diff[cmw_pkg::POS_W-1:0] + ext[cmw_pkg::POS_W-1:0]
                                               : diff[cmw_pkg::POS_W-1:0];
            hi_next[a] = (cmw_pkg::CMP_W'(sum) >= ext)
                       ? sum[cmw_pkg::POS_W-1:0] - ext[cmw_pkg::POS_W-1:0]
                       : sum[cmw_pkg::POS_W-1:0];
        end
    end

    // Per-axis weights
    always_comb
    begin
        part_next.mass = mass1_reg;
        part_next.tag  = tag1_reg;
        for (int a = 0; a < cmw_pkg::AXES; a++)
        begin
            part_next.ax[a].lo = lo_reg[a];
            part_next.ax[a].hi = hi_reg[a];
            part_next.ax[a].wh = cmw_pkg::upper_weight(prod_reg[a]);
            part_next.ax[a].wl = cmw_pkg::ONE_Q32 - part_next.ax[a].wh;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (move0)
                v0_reg <= accept;
            if (move1)
                v1_reg <= v0_reg;
            if (move2)
                v2_reg <= v1_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            mass0_reg  <= mass_in;
            tag0_reg   <= particle_tag;
        end
        if (move1)
        begin
            prod_reg  <= prod_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mass1_reg <= mass0_reg;
            tag1_reg  <= tag0_reg;
        end
        if (move2)
            part_reg <= part_next;
    end

    assign part_valid = v2_reg;
    assign part       = part_reg;

endmodule

FILE: hdl/cmw_corner_pipe.sv
// Corner sequencer and three-stage weight multiply pipeline with the
// result registers. Depends on cmw_pkg.
module cmw_corner_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           part_valid,
    input  cmw_pkg::particle_t             part,
    output logic                           part_take,
    output logic                           strobe,
    output logic [cmw_pkg::POS_W-1:0]      corner_x,
    output logic [cmw_pkg::POS_W-1:0]      corner_y,
    output logic [cmw_pkg::POS_W-1:0]      corner_z,
    output logic [cmw_pkg::MASS_W-1:0]     weight,
    output logic [cmw_pkg::CORNER_W-1:0]   corner_number,
    output logic [cmw_pkg::TAG_W-1:0]      tag_out,
    output logic                           last
);

    // Sequencer
    logic                          active_reg;
    logic [cmw_pkg::CORNER_W-1:0]  k_reg;
    cmw_pkg::particle_t            hold_reg;
    logic                          load;

    // Multiply stages
    logic                          s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [cmw_pkg::MASS_W-1:0]    s1_w_reg, s2_w_reg, out_w_reg;
    logic [cmw_pkg::MASS_W-1:0]    s1_w_next;
    logic [cmw_pkg::WGT_W-1:0]     s1_wy_reg, s1_wz_reg, s2_wz_reg;
    logic [cmw_pkg::POS_W-1:0]     s1_cx_reg, s1_cy_reg, s1_cz_reg;
    logic [cmw_pkg::POS_W-1:0]     s2_cx_reg, s2_cy_reg, s2_cz_reg;
    logic [cmw_pkg::POS_W-1:0]     out_cx_reg, out_cy_reg, out_cz_reg;
    logic [cmw_pkg::CORNER_W-1:0]  s1_k_reg, s2_k_reg, out_k_reg;
    logic [cmw_pkg::TAG_W-1:0]     s1_tag_reg, s2_tag_reg, out_tag_reg;

    // Next particle is taken when idle or while issuing the last corner
    assign part_take = !active_reg || (k_reg == cmw_pkg::LAST_CORNER);
    assign load      = part_valid && part_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
        end
        else if (active_reg)
        begin
            if (k_reg == cmw_pkg::LAST_CORNER)
                active_reg <= 1'b0;
            else
                k_reg <= cmw_pkg::CORNER_W'(k_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            hold_reg <= part;
    end

    // First factor: mass times x weight
    assign s1_w_next = cmw_pkg::mul_weight(hold_reg.mass,
                                           k_reg[0] ? hold_reg.ax[0].wh : hold_reg.ax[0].wl);

    // Valid bits travel with the corners
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= active_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Corner payload
    always_ff @(posedge clk)
    begin
        s1_w_reg   <= s1_w_next;
        s1_wy_reg  <= k_reg[1] ? hold_reg.ax[1].wh : hold_reg.ax[1].wl;
        s1_wz_reg  <= k_reg[2] ? hold_reg.ax[2].wh : hold_reg.ax[2].wl;
        s1_cx_reg  <= k_reg[0] ? hold_reg.ax[0].hi : hold_reg.ax[0].lo;
        s1_cy_reg  <= k_reg[1] ? hold_reg.ax[1].hi : hold_reg.ax[1].lo;
        s1_cz_reg  <= k_reg[2] ? hold_reg.ax[2].hi : hold_reg.ax[2].lo;
        s1_k_reg   <= k_reg;
        s1_tag_reg <= hold_reg.tag;

        s2_w_reg   <= cmw_pkg::mul_weight(s1_w_reg, s1_wy_reg);
        s2_wz_reg  <= s1_wz_reg;
        s2_cx_reg  <= s1_cx_reg;
        s2_cy_reg  <= s1_cy_reg;
        s2_cz_reg  <= s1_cz_reg;
        s2_k_reg   <= s1_k_reg;
        s2_tag_reg <= s1_tag_reg;

        out_w_reg   <= cmw_pkg::mul_weight(s2_w_reg, s2_wz_reg);
        out_cx_reg  <= s2_cx_reg;
        out_cy_reg  <= s2_cy_reg;
        out_cz_reg  <= s2_cz_reg;
        out_k_reg   <= s2_k_reg;
        out_tag_reg <= s2_tag_reg;
    end

    assign strobe        = out_valid_reg;
    assign corner_x      = out_cx_reg;
    assign corner_y      = out_cy_reg;
    assign corner_z      = out_cz_reg;
    assign weight        = out_w_reg;
    assign corner_number = out_k_reg;
    assign tag_out       = out_tag_reg;
    assign last          = out_k_reg == cmw_pkg::LAST_CORNER;

    // Checks
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> active_reg && (k_reg == '0))
        else $error("particle load did not restart the corner count");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && (k_reg != cmw_pkg::LAST_CORNER) |=> active_reg)
        else $error("sequencer stopped before the last corner");

    a_corners_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (corner_number != '0) |-> $past(strobe))
        else $error("gap inside a particle's corner burst");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (corner_number != '0) |->
            (corner_number == cmw_pkg::CORNER_W'($past(corner_number) + 1'b1)))
        else $error("corners out of order");

endmodule

FILE: hdl/cic_mass_weights.sv
// Top level of the cloud-in-cell corner weight block: configuration
// registers, particle front end and corner pipeline. Depends on cmw_pkg,
// cmw_front and cmw_corner_pipe.
//
// One particle is taken at a clock edge with start high and busy low; it
// yields eight corner items on consecutive cycles, each marked by strobe
// for exactly one cycle, corner 0 first and last set on corner 7. The
// result port gives one corner per cycle; a three-deep front end lets up
// to three more particles be taken while a burst is in progress, after
// which busy rises until the sequencer frees a slot. A particle passes the
// front-end stages, the sequencer and the s1, s2 and result registers
// before its first corner appears. Results cannot be held off: the
// receiver must take each strobed item. Write half_cell, inv_cell and
// grid_extent only while no particle is in flight.
module cic_mass_weights (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           write_enable,
    input  logic [cmw_pkg::IDX_W-1:0]      reg_index,
    input  logic [cmw_pkg::CFG_W-1:0]      write_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [cmw_pkg::POS_W-1:0]      pos_x,
    input  logic [cmw_pkg::POS_W-1:0]      pos_y,
    input  logic [cmw_pkg::POS_W-1:0]      pos_z,
    input  logic [cmw_pkg::MASS_W-1:0]     mass_in,
    input  logic [cmw_pkg::TAG_W-1:0]      particle_tag,
    output logic                           strobe,
    output logic [cmw_pkg::POS_W-1:0]      corner_x,
    output logic [cmw_pkg::POS_W-1:0]      corner_y,
    output logic [cmw_pkg::POS_W-1:0]      corner_z,
    output logic [cmw_pkg::MASS_W-1:0]     weight,
    output logic [cmw_pkg::CORNER_W-1:0]   corner_number,
    output logic [cmw_pkg::TAG_W-1:0]      tag_out,
    output logic                           last
);

    logic [cmw_pkg::POS_W-1:0]  half_cell_reg;
    logic [cmw_pkg::CFG_W-1:0]  inv_cell_reg;
    logic [cmw_pkg::GRID_W-1:0] grid_extent_reg;

    logic               part_valid;
    logic               part_take;
    cmw_pkg::particle_t part;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_cell_reg   <= cmw_pkg::HALF_CELL_RST;
            inv_cell_reg    <= cmw_pkg::INV_CELL_RST;
            grid_extent_reg <= cmw_pkg::GRID_EXTENT_RST;
        end
        else if (write_enable)
        begin
            case (cmw_pkg::reg_index_t'(reg_index))
                cmw_pkg::REG_HALF_CELL:   half_cell_reg   <= write_data;
                cmw_pkg::REG_INV_CELL:    inv_cell_reg    <= write_data;
                cmw_pkg::REG_GRID_EXTENT: grid_extent_reg <= write_data[cmw_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    cmw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .mass_in      (mass_in),
        .particle_tag (particle_tag),
        .half_cell    (half_cell_reg),
        .inv_cell     (inv_cell_reg),
        .grid_extent  (grid_extent_reg),
        .part_valid   (part_valid),
        .part         (part),
        .part_take    (part_take)
    );

    cmw_corner_pipe u_corners (
        .clk           (clk),
        .rst_n         (rst_n),
        .part_valid    (part_valid),
        .part          (part),
        .part_take     (part_take),
        .strobe        (strobe),
        .corner_x      (corner_x),
        .corner_y      (corner_y),
        .corner_z      (corner_z),
        .weight        (weight),
        .corner_number (corner_number),
        .tag_out       (tag_out),
        .last          (last)
    );

endmodule
